/* sv/b2bt_pkg.sv */
// ----------------------------------------------------------------------------
// b2bt_pkg
// Shared widths, types and power-of-three constants for the binary to
// balanced ternary converter.
// ----------------------------------------------------------------------------
package b2bt_pkg;

	// number of trits produced for each item
	localparam int NUM_TRITS = 24;
	// fixed field widths
	localparam int VALUE_W   = 40;
	localparam int MASK_W    = 24;
	// signed remainder: magnitude of the input plus a sign bit
	localparam int ACC_W     = VALUE_W + 1;
	// one pipeline stage per trit from the top down to trit 1
	localparam int NUM_STEPS = NUM_TRITS - 1;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [NUM_TRITS-1:0]    trits_t;

	// 3^e, evaluated at elaboration only
	function automatic logic [63:0] pow3(input int e);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < e; k++) begin
			p = p * 64'd3;
		end
		return p;
	endfunction

	// largest magnitude that NUM_TRITS trits can hold: (3^N - 1) / 2
	localparam logic [63:0] LIMIT = (pow3(NUM_TRITS) - 64'd1) >> 1;

endpackage

/* sv/binary_to_balanced_ternary.sv */
// ----------------------------------------------------------------------------
// binary_to_balanced_ternary
// Converts a signed 40-bit integer to a 24-trit balanced ternary form given
// as a mask of +1 trits and a mask of -1 trits.
// ----------------------------------------------------------------------------
// Fully pipelined: one item enters per cycle unless a stall backs up to the
// input, and each item passes NUM_TRITS + 1 register stages: one stage takes
// the magnitude and checks the range, one stage per trit resolves trits
// NUM_TRITS-1 down to 1 with a single compare and add/subtract, and the
// output register resolves trit 0 and applies the sign. Each stage holds
// its item while the next one is full, so bubbles close up under a stall.
// Magnitudes beyond the trit range give overflow set and both masks zero.
module binary_to_balanced_ternary (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [b2bt_pkg::VALUE_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [b2bt_pkg::MASK_W-1:0]  plus_mask,
	output logic [b2bt_pkg::MASK_W-1:0]  minus_mask,
	output logic                         overflow
);
	import b2bt_pkg::*;

	// stage 0 holds the magnitude, stage k has trit NUM_TRITS-k resolved
	logic   vld_s   [0:NUM_STEPS];
	acc_t   acc_s   [0:NUM_STEPS];
	trits_t plus_s  [0:NUM_STEPS];
	trits_t minus_s [0:NUM_STEPS];
	logic   neg_s   [0:NUM_STEPS];
	logic   ovf_s   [0:NUM_STEPS];
	logic   rdy     [0:NUM_STEPS+1];

	logic               out_valid_q;
	logic [MASK_W-1:0]  plus_q;
	logic [MASK_W-1:0]  minus_q;
	logic               ovf_q;

	// stage ready chain: a stage moves when empty or when the next one moves
	always_comb begin
		rdy[NUM_STEPS+1] = !out_valid_q || out_ready;
		for (int k = NUM_STEPS; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];

	// magnitude and range check
	logic                 in_neg;
	logic [VALUE_W-1:0]   in_mag;
	assign in_neg = value[VALUE_W-1];
	assign in_mag = in_neg ? VALUE_W'(-value) : VALUE_W'(value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			acc_s[0]   <= acc_t'({1'b0, in_mag});
			plus_s[0]  <= '0;
			minus_s[0] <= '0;
			neg_s[0]   <= in_neg;
			ovf_s[0]   <= 64'(in_mag) > LIMIT;
		end
	end

	// one trit per stage
	for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
		localparam int          TRIT = NUM_TRITS - k;
		localparam logic [63:0] POW  = pow3(TRIT);
		localparam logic [63:0] HALF = POW >> 1;

		logic [ACC_W-1:0] amag;
		logic             take;
		logic             sgn;

		assign sgn  = acc_s[k-1][ACC_W-1];
		assign amag = sgn ? ACC_W'(-acc_s[k-1]) : ACC_W'(acc_s[k-1]);
		assign take = 64'(amag) > HALF;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		// when taken, 3^TRIT is below twice the remainder and fits ACC_W
		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				acc_s[k]   <= acc_s[k-1];
				plus_s[k]  <= plus_s[k-1];
				minus_s[k] <= minus_s[k-1];
				neg_s[k]   <= neg_s[k-1];
				ovf_s[k]   <= ovf_s[k-1];
				if (take) begin
					if (!sgn) begin
						acc_s[k]        <= acc_s[k-1] - acc_t'(POW[ACC_W-1:0]);
						plus_s[k][TRIT] <= 1'b1;
					end else begin
						acc_s[k]         <= acc_s[k-1] + acc_t'(POW[ACC_W-1:0]);
						minus_s[k][TRIT] <= 1'b1;
					end
				end
			end
		end
	end

	// trit 0, sign swap and overflow clearing
	trits_t fin_plus;
	trits_t fin_minus;
	always_comb begin
		fin_plus  = plus_s[NUM_STEPS];
		fin_minus = minus_s[NUM_STEPS];
		if (acc_s[NUM_STEPS] == acc_t'(1)) begin
			fin_plus[0] = 1'b1;
		end
		if (acc_s[NUM_STEPS] == acc_t'(-1)) begin
			fin_minus[0] = 1'b1;
		end
		if (ovf_s[NUM_STEPS]) begin
			fin_plus  = '0;
			fin_minus = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[NUM_STEPS+1]) begin
			out_valid_q <= vld_s[NUM_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NUM_STEPS+1] && vld_s[NUM_STEPS]) begin
			plus_q  <= MASK_W'(neg_s[NUM_STEPS] ? fin_minus : fin_plus);
			minus_q <= MASK_W'(neg_s[NUM_STEPS] ? fin_plus : fin_minus);
			ovf_q   <= ovf_s[NUM_STEPS];
		end
	end

	assign out_valid  = out_valid_q;
	assign plus_mask  = plus_q;
	assign minus_mask = minus_q;
	assign overflow   = ovf_q;

	// checks
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> plus_mask == '0 && minus_mask == '0)
		else $error("overflow result with nonzero masks");

	a_trit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (plus_mask & minus_mask) == '0)
		else $error("trit marked both +1 and -1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NUM_STEPS] && !out_valid_q |=> out_valid_q)
		else $error("last stage item not moved to output");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks binary_to_balanced_ternary against an in-bench trit predictor.
// A directed set of corner values runs first, then random values weighted
// toward the trit range, its bounds and powers of three. Both handshake sides
// idle at random. Results are compared in order, one field at a time.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b2bt_pkg::*;

	localparam int NUM_RANDOM = 1925;
	// receiver hold-off: starts once this many items went in; HOLD_LEN sets its length
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 400;
	// cycles to linger after the last result (pipeline is NUM_TRITS + 1 deep)
	localparam int TAIL       = 2 * NUM_TRITS + 10;

	// 3^e
	function automatic longint three_pow(input int e);
		longint p;
		p = 1;
		for (int k = 0; k < e; k++) begin
			p = p * 3;
		end
		return p;
	endfunction

	// largest magnitude the trits can hold
	localparam longint TERN_MAX = (three_pow(NUM_TRITS) - 1) / 2;

	typedef struct {
		logic [VALUE_W-1:0] src;
		logic [MASK_W-1:0]  plus;
		logic [MASK_W-1:0]  minus;
		logic               ovf;
	} conv_t;

	typedef struct {
		logic [VALUE_W-1:0] v;
		int                 gap;   // idle cycles before the item is offered
		bit                 drain; // hold until every result is back
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [MASK_W-1:0] plus_mask;
	logic [MASK_W-1:0] minus_mask;
	logic overflow;

	item_t item_q[$];
	conv_t conv_q[$];
	int n_sent = 0;
	int n_done = 0;
	int n_err = 0;
	int rx_wait = 0;
	int hold_cnt = 0;
	bit rx_hold = 1'b0;
	bit hold_done = 1'b0;
	bit tx_fire;
	int rx_w;
	conv_t got;
	conv_t want;

	binary_to_balanced_ternary u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.plus_mask  (plus_mask),
		.minus_mask (minus_mask),
		.overflow   (overflow)
	);

	always #2 clk = ~clk;

	// expected trit masks for one input value
	function automatic conv_t to_ternary(input logic [VALUE_W-1:0] v);
		conv_t r;
		logic [VALUE_W-1:0] m;
		logic [MASK_W-1:0] t;
		longint acc;
		longint p;
		r.src = v;
		r.plus = '0;
		r.minus = '0;
		r.ovf = 1'b0;
		m = v[VALUE_W-1] ? (~v + 1'b1) : v;
		if (longint'({24'd0, m}) > TERN_MAX) begin
			r.ovf = 1'b1;
			return r;
		end
		acc = longint'({24'd0, m});
		p = three_pow(NUM_TRITS - 1);
		// top trit first; a trit is set once the remainder passes half of 3^i
		for (int i = NUM_TRITS - 1; i >= 1; i--) begin
			if (acc > p / 2) begin
				acc -= p;
				if (i < MASK_W) r.plus[i] = 1'b1;
			end else if (acc < -(p / 2)) begin
				acc += p;
				if (i < MASK_W) r.minus[i] = 1'b1;
			end
			p = p / 3;
		end
		if (acc == 1) r.plus[0] = 1'b1;
		else if (acc == -1) r.minus[0] = 1'b1;
		// negative input flips every trit
		if (v[VALUE_W-1]) begin
			t = r.plus;
			r.plus = r.minus;
			r.minus = t;
		end
		return r;
	endfunction

	// random value, mostly inside the trit range
	function automatic logic [VALUE_W-1:0] draw_value();
		logic [VALUE_W-1:0] raw;
		longint r;
		longint p3;
		int pick;
		raw = {8'($urandom()), 32'($urandom())};
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			r = longint'({24'd0, raw}) % (2 * TERN_MAX + 1) - TERN_MAX;
		end else if (pick < 70) begin
			r = longint'($urandom_range(0, 2000)) - 1000;
		end else if (pick < 80) begin
			r = TERN_MAX - 20 + longint'($urandom_range(0, 40));
			if ($urandom_range(0, 1)) r = -r;
		end else if (pick < 88) begin
			// around a power of three or its half
			p3 = three_pow($urandom_range(0, NUM_TRITS - 1));
			r = $urandom_range(0, 1) ? p3 : p3 / 2;
			r = r + longint'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1)) r = -r;
		end else begin
			r = longint'({24'd0, raw});
		end
		return r[VALUE_W-1:0];
	endfunction

	// sender: offers queued items, holds each until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			n_sent <= 0;
		end else begin
			tx_fire = in_valid && in_ready;
			if (tx_fire) begin
				conv_q.push_back(to_ternary(value));
				n_sent <= n_sent + 1;
			end
			if (in_valid && !tx_fire) begin
				// keep offering the same item
			end else if (item_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (item_q[0].drain && (tx_fire || n_sent != n_done)) begin
				in_valid <= 1'b0;
			end else if (item_q[0].gap != 0) begin
				item_q[0].gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				value <= item_q[0].v;
				item_q.pop_front();
			end
		end
	end

	// long receiver hold-off, once, while the sender keeps pushing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
			hold_done <= 1'b0;
			hold_cnt <= 0;
		end else if (!hold_done && !rx_hold && n_sent >= HOLD_AT) begin
			rx_hold <= 1'b1;
			hold_cnt <= HOLD_LEN;
		end else if (rx_hold) begin
			if (hold_cnt == 1) begin
				rx_hold <= 1'b0;
				hold_done <= 1'b1;
			end
			hold_cnt <= hold_cnt - 1;
		end
	end

	// receiver: random stalls, checks each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
			n_done <= 0;
		end else begin
			rx_w = rx_wait;
			if (out_valid && out_ready) begin
				got.plus = plus_mask;
				got.minus = minus_mask;
				got.ovf = overflow;
				if (conv_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: plus %h minus %h ovf %b",
							got.plus, got.minus, got.ovf);
				end else begin
					want = conv_q.pop_front();
					if (got.plus !== want.plus || got.minus !== want.minus ||
							got.ovf !== want.ovf) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch value %0d: plus %h/%h minus %h/%h ovf %b/%b",
								$signed(want.src), want.plus, got.plus,
								want.minus, got.minus, want.ovf, got.ovf);
					end
				end
				n_done <= n_done + 1;
				// every third stretch of 150 results runs without stalls
				rx_w = ((n_done / 150) % 3 == 1) ? 0 : $urandom_range(0, 17);
			end else if (rx_w != 0) begin
				rx_w--;
			end
			rx_wait <= rx_w;
			out_ready <= (rx_w == 0) && !rx_hold;
		end
	end

	// stimulus and end of run
	longint corners[$] = '{
		0, 1, -1, 2, -2, 4, 13, -13, 121, -40,
		64'sd47071589413, 64'sd47071589414, -64'sd47071589414,
		64'sd94143178827, -64'sd94143178827,
		64'sd141214768240, -64'sd141214768240, 64'sd141214768241, -64'sd141214768241,
		64'sd549755813887, -64'sd549755813888,
		64'sd366503875925, -64'sd366503875926
	};

	initial begin
		item_t it;
		foreach (corners[k]) begin
			it.v = corners[k][VALUE_W-1:0];
			it.gap = $urandom_range(0, 17);
			it.drain = 1'b0;
			item_q.push_back(it);
		end
		for (int k = 0; k < NUM_RANDOM; k++) begin
			it.v = draw_value();
			// back-to-back stretches, and back-to-back around the hold-off
			if ((k / 100) % 3 == 0 || (k >= HOLD_AT - 40 && k < HOLD_AT + 120))
				it.gap = 0;
			else
				it.gap = $urandom_range(0, 17);
			it.drain = (k == 0 || k == 1000);
			item_q.push_back(it);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (item_q.size() != 0 || in_valid) @(posedge clk);
		while (n_done < n_sent) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (conv_q.size() != 0) n_err++;

		if (n_err == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
